// ----- rtl/spherical_fold_offset_macros.svh -----
// Assertion macros shared by the spherical fold offset RTL.
`ifndef SPHERICAL_FOLD_OFFSET_MACROS_SVH
`define SPHERICAL_FOLD_OFFSET_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define SFO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define SFO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sfo_pkg.sv -----
// Shared widths, payload type and register indexes of the spherical fold offset block.
package sfo_pkg;
  localparam int COORD_W    = 32;
  localparam int DE_W       = 40;
  localparam int FRAC_W     = 24;
  localparam int MINR2_W    = 25;
  localparam int SQ_W       = 2 * FRAC_W;
  localparam int SCALE_W    = 2 * FRAC_W + 1;
  localparam int DIV_STAGES = SCALE_W;
  localparam int TWEAK_W    = 42;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 40;
  localparam int LANES      = 4;

  typedef struct packed {
    logic signed [DE_W-1:0]    de;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OFFSET_X  = 3'd0,
    REG_OFFSET_Y  = 3'd1,
    REG_OFFSET_Z  = 3'd2,
    REG_OFFSET_W  = 3'd3,
    REG_MIN_R2    = 3'd4,
    REG_TWEAK_EN  = 3'd5,
    REG_DE_SCALE  = 3'd6,
    REG_DE_OFFSET = 3'd7
  } cfg_reg_t;
endpackage

// ----- rtl/spherical_fold_offset.sv -----
// Spherical fold offset: a 4-D spherical fold of a Q8.24 point with distance-estimate scaling.
// The block takes one point per clock unless its output stalls it, and returns one folded point
// per point, in order. Four coordinate lanes form |c| - offset and its square, merge stages sum
// the squares and pick the divisor, and a 49-stage pipelined divider forms the fold scale one
// quotient bit per stage; scaling multipliers and the optional estimate tweak follow. While
// out_tready is low the pipeline keeps moving until its last stage holds an item, so new points
// are still taken while a result waits.
module spherical_fold_offset (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sfo_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sfo_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata from bit 0: in_x[31:0], in_y, in_z, in_w (32 each), in_de (40)
  input  logic [sfo_pkg::ITEM_W-1:0]         in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata from bit 0: out_x[31:0], out_y, out_z, out_w (32 each), out_de (40)
  output logic [sfo_pkg::ITEM_W-1:0]         out_tdata
);
  import sfo_pkg::*;

  localparam int FRONT = 7;
  localparam int MUL_L = 4;
  localparam int TS_W  = TWEAK_W + 2;

  // Configuration registers.
  logic signed [COORD_W-1:0] off_r [LANES];
  logic [MINR2_W-1:0]        min_r2_r;
  logic                      tweak_en_r;
  logic signed [COORD_W-1:0] de_scale_r;
  logic signed [DE_W-1:0]    de_offset_r;

  logic [MINR2_W-1:0] m_eff;
  logic [SCALE_W-1:0] mq;
  logic               ds_neg;
  logic [COORD_W-1:0] dsm;
  logic               en;

  logic  v_r    [FRONT];
  item_t item_r [FRONT];

  logic signed [COORD_W-1:0] lane_c  [LANES];
  logic        [SQ_W-1:0]    lane_sq [LANES];
  logic        [LANES-1:0]   lane_big;

  logic [SQ_W:0]      s01_r, s23_r;
  logic               big4_r, big5_r;
  logic [SQ_W+1:0]    r2_r;
  logic [SCALE_W-1:0] d_nxt;
  logic [SCALE_W-1:0] div_d_r;

  logic               div_v;
  logic [SCALE_W-1:0] div_q;
  item_t              div_item;
  logic signed [COORD_W-1:0] div_c [LANES];
  logic signed [COORD_W-1:0] mc    [LANES];
  logic signed [DE_W-1:0]    mde;
  logic                      vm_r  [MUL_L];
  logic signed [TWEAK_W-1:0] pt;
  item_t                     cd_r  [MUL_L];
  logic                      vt_r  [MUL_L];

  logic signed [TS_W-1:0]    tsum;
  logic                      fits;
  logic signed [DE_W-1:0]    de_sat;
  item_t                     fin_nxt;
  item_t                     fin_r;
  logic                      vf_r;
  item_t                     out_item_r;
  logic                      out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        off_r[i] <= '0;
      end
      min_r2_r    <= MINR2_W'(4194304);
      tweak_en_r  <= 1'b0;
      de_scale_r  <= COORD_W'(16777216);
      de_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_OFFSET_X:  off_r[0]    <= cfg_wdata[COORD_W-1:0];
        REG_OFFSET_Y:  off_r[1]    <= cfg_wdata[COORD_W-1:0];
        REG_OFFSET_Z:  off_r[2]    <= cfg_wdata[COORD_W-1:0];
        REG_OFFSET_W:  off_r[3]    <= cfg_wdata[COORD_W-1:0];
        REG_MIN_R2:    min_r2_r    <= cfg_wdata[MINR2_W-1:0];
        REG_TWEAK_EN:  tweak_en_r  <= cfg_wdata[0];
        REG_DE_SCALE:  de_scale_r  <= cfg_wdata[COORD_W-1:0];
        REG_DE_OFFSET: de_offset_r <= cfg_wdata[DE_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero minimum radius acts as one LSB.
  assign m_eff  = (min_r2_r == '0) ? MINR2_W'(1) : min_r2_r;
  assign mq     = {m_eff, {FRAC_W{1'b0}}};
  assign ds_neg = de_scale_r[COORD_W-1];
  assign dsm    = ds_neg ? COORD_W'(-de_scale_r) : COORD_W'(de_scale_r);

  // The whole pipeline advances unless its last stage is blocked by a full output register.
  assign en        = !vf_r || !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FRONT; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int k = 1; k < FRONT; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= item_t'(in_tdata);
      for (int k = 1; k < FRONT; k++) begin
        item_r[k] <= item_r[k-1];
      end
    end
  end

  assign lane_c[0] = item_r[0].x;
  assign lane_c[1] = item_r[0].y;
  assign lane_c[2] = item_r[0].z;
  assign lane_c[3] = item_r[0].w;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sfo_lane u_lane (
      .clk    (clk),
      .en     (en),
      .coord  (lane_c[i]),
      .offset (off_r[i]),
      .sq     (lane_sq[i]),
      .big    (lane_big[i])
    );
  end

  // Divisor choice: 2^72 / (min_r2 << 24) gives 1/min_r2 and 2^72 / 2^48 gives one.
  always_comb begin
    if (m_eff[MINR2_W-1]) begin
      d_nxt = mq;
    end else if (big5_r || (|r2_r[SQ_W+1:SQ_W])) begin
      d_nxt = SCALE_W'(1) << SQ_W;
    end else if (r2_r <= (SQ_W+2)'(mq)) begin
      d_nxt = mq;
    end else begin
      d_nxt = SCALE_W'(r2_r[SQ_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s01_r   <= (SQ_W+1)'(lane_sq[0]) + (SQ_W+1)'(lane_sq[1]);
      s23_r   <= (SQ_W+1)'(lane_sq[2]) + (SQ_W+1)'(lane_sq[3]);
      big4_r  <= |lane_big;
      r2_r    <= (SQ_W+2)'(s01_r) + (SQ_W+2)'(s23_r);
      big5_r  <= big4_r;
      div_d_r <= d_nxt;
    end
  end

  sfo_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r[FRONT-1]),
    .in_d      (div_d_r),
    .in_item   (item_r[FRONT-1]),
    .out_valid (div_v),
    .out_q     (div_q),
    .out_item  (div_item)
  );

  assign div_c[0] = div_item.x;
  assign div_c[1] = div_item.y;
  assign div_c[2] = div_item.z;
  assign div_c[3] = div_item.w;

  for (genvar i = 0; i < LANES; i++) begin : g_cmul
    sfo_mul #(
      .V_W (COORD_W),
      .S_W (SCALE_W),
      .R_W (COORD_W)
    ) u_cmul (
      .clk (clk),
      .en  (en),
      .v   (div_c[i]),
      .s   (div_q),
      .r   (mc[i])
    );
  end

  sfo_mul #(
    .V_W (DE_W),
    .S_W (SCALE_W),
    .R_W (DE_W)
  ) u_demul (
    .clk (clk),
    .en  (en),
    .v   (div_item.de),
    .s   (div_q),
    .r   (mde)
  );

  sfo_mul #(
    .V_W (DE_W),
    .S_W (COORD_W),
    .R_W (TWEAK_W)
  ) u_tmul (
    .clk (clk),
    .en  (en),
    .v   (mde),
    .s   (dsm),
    .r   (pt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MUL_L; k++) begin
        vm_r[k] <= 1'b0;
        vt_r[k] <= 1'b0;
      end
      vf_r <= 1'b0;
    end else if (en) begin
      vm_r[0] <= div_v;
      vt_r[0] <= vm_r[MUL_L-1];
      for (int k = 1; k < MUL_L; k++) begin
        vm_r[k] <= vm_r[k-1];
        vt_r[k] <= vt_r[k-1];
      end
      vf_r <= vt_r[MUL_L-1];
    end
  end

  // Scaled results wait here while the estimate goes through the tweak multiplier.
  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= '{de: mde, w: mc[3], z: mc[2], y: mc[1], x: mc[0]};
      for (int k = 1; k < MUL_L; k++) begin
        cd_r[k] <= cd_r[k-1];
      end
      fin_r <= fin_nxt;
    end
  end

  assign tsum   = (ds_neg ? (TS_W'(0) - TS_W'(pt)) : TS_W'(pt)) + TS_W'(de_offset_r);
  assign fits   = (tsum[TS_W-1:DE_W-1] == '0) || (tsum[TS_W-1:DE_W-1] == '1);
  assign de_sat = fits ? tsum[DE_W-1:0]
                       : (tsum[TS_W-1] ? {1'b1, {(DE_W-1){1'b0}}} : {1'b0, {(DE_W-1){1'b1}}});

  always_comb begin
    fin_nxt = cd_r[MUL_L-1];
    if (tweak_en_r) begin
      fin_nxt.de = de_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vf_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vf_r) begin
      out_item_r <= fin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;
endmodule

// ----- rtl/sfo_lane.sv -----
// One coordinate lane: folded distance from the offset and its square.
module sfo_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [sfo_pkg::COORD_W-1:0]  coord,
  input  logic signed [sfo_pkg::COORD_W-1:0]  offset,
  output logic        [sfo_pkg::SQ_W-1:0]     sq,
  output logic                                big
);
  import sfo_pkg::*;

  localparam int A_W  = COORD_W + 2;
  localparam int AM_W = COORD_W + 1;

  logic signed [A_W-1:0]  cx;
  logic signed [A_W-1:0]  a_nxt;
  logic signed [A_W-1:0]  a_r;
  logic        [AM_W-1:0] am;
  logic        [FRAC_W-1:0] am_r;
  logic                   big1_r;
  logic                   big2_r;
  logic        [SQ_W-1:0] sq_r;

  assign cx    = A_W'(coord);
  assign a_nxt = ((cx < 0) ? -cx : cx) - A_W'(offset);
  assign am    = (a_r < 0) ? AM_W'(-a_r) : AM_W'(a_r);

  // A distance of 1.0 or more forces the scale to one, so only the low bits get squared.
  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      am_r   <= am[FRAC_W-1:0];
      big1_r <= |am[AM_W-1:FRAC_W];
      sq_r   <= SQ_W'(am_r) * SQ_W'(am_r);
      big2_r <= big1_r;
    end
  end

  assign sq  = sq_r;
  assign big = big2_r;
endmodule

// ----- rtl/sfo_div.sv -----
// Pipelined restoring divider that forms the fold scale floor(2^72 / d), one bit per stage.
`include "spherical_fold_offset_macros.svh"
module sfo_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [sfo_pkg::SCALE_W-1:0]     in_d,
  input  sfo_pkg::item_t                  in_item,
  output logic                            out_valid,
  output logic [sfo_pkg::SCALE_W-1:0]     out_q,
  output sfo_pkg::item_t                  out_item
);
  import sfo_pkg::*;

  localparam logic [SCALE_W-1:0] REM0  = SCALE_W'(1) << (FRAC_W - 1);
  localparam logic [SCALE_W-1:0] D_MIN = SCALE_W'(1) << FRAC_W;
  localparam logic [SCALE_W-1:0] Q_MAX = SCALE_W'(1) << (SCALE_W - 1);

  logic               v_r    [DIV_STAGES];
  logic [SCALE_W-1:0] rem_r  [DIV_STAGES];
  logic [SCALE_W-1:0] d_r    [DIV_STAGES];
  logic [SCALE_W-1:0] q_r    [DIV_STAGES];
  item_t              item_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic               v_i;
    logic [SCALE_W-1:0] rem_i;
    logic [SCALE_W-1:0] d_i;
    logic [SCALE_W-1:0] q_i;
    item_t              item_i;
    logic [SCALE_W:0]   t;
    logic [SCALE_W:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = REM0;
      assign d_i    = in_d;
      assign q_i    = '0;
      assign item_i = in_item;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign d_i    = d_r[k-1];
      assign q_i    = q_r[k-1];
      assign item_i = item_r[k-1];
    end

    // The dividend below its top bits is all zeros, so each step shifts in a zero.
    assign t    = {rem_i, 1'b0};
    assign ge   = t >= {1'b0, d_i};
    assign diff = t - {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[SCALE_W-1:0] : t[SCALE_W-1:0];
        d_r[k]    <= d_i;
        q_r[k]    <= {q_i[SCALE_W-2:0], ge};
        item_r[k] <= item_i;
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_q     = q_r[DIV_STAGES-1];
  assign out_item  = item_r[DIV_STAGES-1];

  `SFO_ASSERT_IMP(a_div_d_min, in_valid && en, in_d >= D_MIN, "divisor below one")
  `SFO_ASSERT_NXT(a_div_enter, in_valid && en, v_r[0], "item lost at divider entry")
  `SFO_ASSERT_IMP(a_div_rem, v_r[DIV_STAGES-1], rem_r[DIV_STAGES-1] < d_r[DIV_STAGES-1], "remainder not below divisor")
  `SFO_ASSERT_IMP(a_div_q, out_valid, (out_q <= Q_MAX) && (out_q >= REM0), "fold scale out of range")
endmodule

// ----- rtl/sfo_mul.sv -----
// Four-stage signed-by-unsigned Q.24 scaling multiplier with truncation and saturation.
module sfo_mul #(
  parameter int V_W = sfo_pkg::DE_W,
  parameter int S_W = sfo_pkg::SCALE_W,
  parameter int R_W = sfo_pkg::DE_W
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [V_W-1:0] v,
  input  logic        [S_W-1:0] s,
  output logic signed [R_W-1:0] r
);
  import sfo_pkg::*;

  localparam int ML_W = V_W / 2;
  localparam int MH_W = V_W - ML_W;
  localparam int SL_W = FRAC_W;
  localparam int SH_W = S_W - FRAC_W;
  localparam int LL_W = ML_W + SL_W;
  localparam int LH_W = ML_W + SH_W;
  localparam int HL_W = MH_W + SL_W;
  localparam int HH_W = MH_W + SH_W;
  localparam int P_W  = V_W + S_W;
  localparam int PR_W = P_W - FRAC_W;

  logic              neg1_r, neg2_r, neg3_r;
  logic [V_W-1:0]    mag1_r;
  logic [S_W-1:0]    s1_r;
  logic [LL_W-1:0]   pll_r;
  logic [LH_W-1:0]   plh_r;
  logic [HL_W-1:0]   phl_r;
  logic [HH_W-1:0]   phh_r;
  logic [P_W-1:0]    sum;
  logic [PR_W-1:0]   prod_r;
  logic [PR_W-1:0]   lim;
  logic [PR_W-1:0]   mg;
  logic signed [R_W-1:0] r_r;

  assign sum = (P_W'(phh_r) << (ML_W + SL_W)) + (P_W'(phl_r) << ML_W)
             + (P_W'(plh_r) << SL_W) + P_W'(pll_r);

  // The negative side may reach one step further than the positive side.
  assign lim = neg3_r ? (PR_W'(1) << (R_W - 1)) : ((PR_W'(1) << (R_W - 1)) - PR_W'(1));
  assign mg  = (prod_r > lim) ? lim : prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= v[V_W-1];
      mag1_r <= v[V_W-1] ? V_W'(-v) : V_W'(v);
      s1_r   <= s;
      neg2_r <= neg1_r;
      pll_r  <= LL_W'(mag1_r[ML_W-1:0]) * LL_W'(s1_r[SL_W-1:0]);
      plh_r  <= LH_W'(mag1_r[ML_W-1:0]) * LH_W'(s1_r[S_W-1:SL_W]);
      phl_r  <= HL_W'(mag1_r[V_W-1:ML_W]) * HL_W'(s1_r[SL_W-1:0]);
      phh_r  <= HH_W'(mag1_r[V_W-1:ML_W]) * HH_W'(s1_r[S_W-1:SL_W]);
      neg3_r <= neg2_r;
      prod_r <= sum[P_W-1:FRAC_W];
      r_r    <= neg3_r ? R_W'(PR_W'(0) - mg) : R_W'(mg);
    end
  end

  assign r = r_r;
endmodule

// ----- tb/sv/sfo_checker.sv -----
// Checker for the spherical fold offset block: predicts each folded point and compares.
module sfo_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfo_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [sfo_pkg::ITEM_W-1:0]     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [sfo_pkg::ITEM_W-1:0]     out_tdata,
  output int                             fail_cnt,
  output int                             pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfo_pkg::*;

  localparam logic [127:0] ONE_Q24 = 128'd1 << 24;
  localparam logic [127:0] ONE_Q48 = 128'd1 << 48;
  localparam logic [127:0] ONE_Q72 = 128'd1 << 72;

  longint           fold_offset [4];
  logic [24:0]      min_r2_q;
  bit               tweak_en;
  longint           de_scale_q;
  longint           de_offset_q;
  item_t            folded_q [$];

  // Truncated magnitude product with saturation to a w-bit signed range.
  function automatic longint scale_sat(longint v, logic [127:0] k, int w);
    logic [127:0] mag, prod, lim;
    bit           neg;
    neg  = v < 0;
    mag  = neg ? 128'(-v) : 128'(v);
    prod = (mag * k) >> 24;
    lim  = neg ? (128'd1 << (w - 1)) : (128'd1 << (w - 1)) - 1;
    if (prod > lim) prod = lim;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic item_t fold_point(item_t p);
    longint       c [4];
    longint       de, a, ds, tw;
    logic [127:0] r2, k, am, m, dsm;
    bit           big;
    item_t        r;
    c[0] = p.x; c[1] = p.y; c[2] = p.z; c[3] = p.w;
    de = p.de;
    m = 128'(min_r2_q);
    if (m == 0) m = 1;
    if (m >= ONE_Q24) begin
      k = ONE_Q48 / m;
    end else begin
      r2  = 0;
      big = 0;
      for (int i = 0; i < 4; i++) begin
        a  = (c[i] < 0 ? -c[i] : c[i]) - fold_offset[i];
        am = a < 0 ? 128'(-a) : 128'(a);
        if (am >= ONE_Q24) big = 1;
        else r2 += am * am;
      end
      if (big || r2 >= ONE_Q48) k = ONE_Q24;
      else if (r2 <= (m << 24)) k = ONE_Q48 / m;
      else k = ONE_Q72 / r2;
    end
    r.x = 32'(scale_sat(c[0], k, 32));
    r.y = 32'(scale_sat(c[1], k, 32));
    r.z = 32'(scale_sat(c[2], k, 32));
    r.w = 32'(scale_sat(c[3], k, 32));
    de = scale_sat(de, k, 40);
    if (tweak_en) begin
      ds  = de_scale_q;
      dsm = ds < 0 ? 128'(-ds) : 128'(ds);
      tw  = scale_sat(de, dsm, 42);
      if (ds < 0) tw = -tw;
      tw += de_offset_q;
      if (tw > 64'sd549755813887) tw = 64'sd549755813887;
      if (tw < -64'sd549755813888) tw = -64'sd549755813888;
      de = tw;
    end
    r.de = de[39:0];
    return r;
  endfunction

  // Inputs change only at rising edges, so the falling edge sees what the next rise accepts.
  always @(negedge clk) begin
    item_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) fold_offset[i] = 0;
      min_r2_q    = 25'd4194304;
      tweak_en    = 0;
      de_scale_q  = 64'sd16777216;
      de_offset_q = 0;
      folded_q.delete();
      fail_cnt    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z, REG_OFFSET_W:
            fold_offset[cfg_addr] = longint'($signed(cfg_wdata[31:0]));
          REG_MIN_R2:    min_r2_q    = cfg_wdata[24:0];
          REG_TWEAK_EN:  tweak_en    = cfg_wdata[0];
          REG_DE_SCALE:  de_scale_q  = longint'($signed(cfg_wdata[31:0]));
          REG_DE_OFFSET: de_offset_q = longint'($signed(cfg_wdata[39:0]));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) folded_q.push_back(fold_point(item_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = item_t'(out_tdata);
        if (folded_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result transfer: %h", got);
        end else begin
          want = folded_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.w !== want.w || got.de !== want.de) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: exp x=%h y=%h z=%h w=%h de=%h, got x=%h y=%h z=%h w=%h de=%h",
                       want.x, want.y, want.z, want.w, want.de,
                       got.x, got.y, got.z, got.w, got.de);
          end
        end
      end
    end
    pending_cnt = folded_q.size();
  end
endmodule

// ----- tb/sv/testbench.sv -----
// Top of the spherical fold offset testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfo_pkg::*;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [ITEM_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [ITEM_W-1:0]     out_tdata;
  int                    fail_cnt;
  int                    pending_cnt;
  bit                    calm = 0;
  int                    stall_left = 0;
  logic signed [31:0]    cur_offset [4];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  spherical_fold_offset dut (.*);

  sfo_checker checker_i (.*);

  always @(posedge clk) begin
    if (!calm && stall_left == 0 && $urandom_range(0, 15) == 0)
      stall_left = $urandom_range(1, 17);
    if (stall_left > 0) begin
      out_tready <= 0;
      stall_left--;
    end else begin
      out_tready <= 1;
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    if (r <= REG_OFFSET_W) cur_offset[r] = v[31:0];
  endtask

  task automatic set_fold(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz, logic [31:0] ow,
                          logic [24:0] mr2, bit en, logic [31:0] dsc, logic [39:0] dof);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_OFFSET_W, ow);
    write_reg(REG_MIN_R2, mr2);
    write_reg(REG_TWEAK_EN, en);
    write_reg(REG_DE_SCALE, dsc);
    write_reg(REG_DE_OFFSET, dof);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic push_point(item_t v);
    int gap;
    gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= v;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // Waits until every point has come back, then lets the pipeline settle.
  task automatic drain();
    in_tvalid <= 0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic item_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] w, logic [39:0] de);
    item_t p;
    p.x = x; p.y = y; p.z = z; p.w = w; p.de = de;
    return p;
  endfunction

  // Most coordinates land near the fold center so that r2 falls below one.
  function automatic logic [31:0] rand_coord(logic signed [31:0] off);
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v = off + ($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        if ($urandom_range(0, 1)) v = -v;
      end
      4, 5: v = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      6: v = 0;
      7: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [39:0] rand_de();
    logic [39:0] d;
    case ($urandom_range(0, 5))
      0: d = $urandom_range(0, 1) ? 40'h7fffffffff : 40'h8000000000;
      1, 2: d = 40'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
      default: d = 40'({$urandom, $urandom});
    endcase
    return d;
  endfunction

  function automatic logic [31:0] rand_offset();
    return $urandom_range(0, 3) == 0 ? $urandom
                                     : 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  task automatic run_directed();
    item_t pts [$];
    pts = '{mk(0, 0, 0, 0, 0),
            mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 40'h7fffffffff),
            mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 40'h8000000000),
            mk(32'h0199999a, 32'h0199999a, 32'h0199999a, 32'h0199999a, 40'h0001000000),
            mk(32'h04cccccd, 32'hfb333333, 32'h04cccccd, 32'h04cccccd, 40'hffff000000),
            mk(32'hfe666666, 0, 0, 0, 40'h7fffffffff),
            mk(32'h01000000, 0, 0, 0, 40'h8000000000),
            mk(32'h00800000, 32'hff800000, 0, 32'h00400000, 40'h0123456789),
            mk(32'h80000000, 0, 0, 0, 40'h0000000001),
            mk(0, 0, 32'h00000001, 32'hffffffff, 40'hffffffffff)};
    foreach (pts[i]) push_point(pts[i]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    for (int i = 0; i < 4; i++) cur_offset[i] = 0;
    @(posedge clk);

    // Reset settings first, then the register extremes.
    run_directed();
    drain();
    set_fold(32'h0199999a, 32'h0199999a, 32'h0199999a, 32'h0199999a,
             25'd1, 1, 32'h7fffffff, 40'h8000000000);
    run_directed();
    drain();
    set_fold(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             25'd16777216, 1, 32'h80000000, 40'h7fffffffff);
    repeat (30) push_point(mk(rand_coord(cur_offset[0]), rand_coord(cur_offset[1]),
                              rand_coord(cur_offset[2]), rand_coord(cur_offset[3]), rand_de()));
    drain();
    // A zero minimum radius acts as one step.
    set_fold(32'h7fffffff, 0, 32'h00800000, 32'hff800000, 25'd0, 0, 0, 0);
    repeat (30) push_point(mk(rand_coord(cur_offset[0]), rand_coord(cur_offset[1]),
                              rand_coord(cur_offset[2]), rand_coord(cur_offset[3]), rand_de()));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_fold(rand_offset(), rand_offset(), rand_offset(), rand_offset(),
               25'($urandom_range(0, 1) ? $urandom_range(1, 1 << 24)
                                         : $urandom_range(1, 1 << 23)),
               1'($urandom_range(0, 1)),
               $urandom_range(0, 2) == 0 ? $urandom
                                         : 32'($urandom_range(1 << 22, 1 << 25)),
               $urandom_range(0, 1) ? 40'({$urandom, $urandom})
                                    : 40'($signed($urandom_range(0, 1 << 26)) - (1 << 25)));
      if (ph == 4) calm = 1;
      repeat (60) push_point(mk(rand_coord(cur_offset[0]), rand_coord(cur_offset[1]),
                                rand_coord(cur_offset[2]), rand_coord(cur_offset[3]), rand_de()));
      drain();
    end

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
